// ===== sv/tcfb_pkg.sv =====
// ----------------------------------------------------------------------------
// tcfb_pkg
// Shared types and constants of the text cell frame buffer: screen geometry,
// command and status codes, and the control state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package tcfb_pkg;

  localparam int COLUMNS = 209;
  localparam int ROWS    = 56;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 16;
  localparam int CELL_W  = CHAR_W + ATTR_W;
  localparam int COORD_W = 16;
  localparam int SIZE_W  = 10;

  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_PUT    = 3'd1,
    CMD_BEGIN  = 3'd2,
    CMD_SPRITE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_WRITTEN = 3'd0,
    ST_OUTSIDE = 3'd1,
    ST_MOVED   = 3'd2,
    ST_READ    = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_READ
  } state_t;

  // on-screen flag and linear cell address for one coordinate pair
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } cell_loc_t;

endpackage

`default_nettype wire

// ===== sv/tcfb_ram.sv =====
// ----------------------------------------------------------------------------
// tcfb_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== sv/tcfb_addr.sv =====
// ----------------------------------------------------------------------------
// tcfb_addr
// Maps a signed column/row pair onto the row-major cell address and flags
// whether it lies on the screen.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfb_addr
  import tcfb_pkg::*;
(
  input  wire logic signed [COORD_W-1:0] col,
  input  wire logic signed [COORD_W-1:0] row,
  output cell_loc_t                      loc
);

  logic col_ok;
  logic row_ok;

  assign col_ok = !col[COORD_W-1] && (col[COORD_W-2:0] < (COORD_W-1)'(COLUMNS));
  assign row_ok = !row[COORD_W-1] && (row[COORD_W-2:0] < (COORD_W-1)'(ROWS));

  always_comb begin
    loc.hit  = col_ok && row_ok;
    loc.addr = ADDR_W'(row[ROW_W-1:0]) * ADDR_W'(COLUMNS) + ADDR_W'(col[COL_W-1:0]);
  end

endmodule

`default_nettype wire

// ===== sv/text_cell_frame_buffer.sv =====
// ----------------------------------------------------------------------------
// text_cell_frame_buffer
// Character-cell text frame buffer with sprite cursor and cell reads.
// ----------------------------------------------------------------------------
// Commands arrive on the in_ stream, one per beat, command code in in_tuser.
// Every command gives exactly one result beat on the out_ stream, status in
// out_tuser and the cell read (or zeros) in out_tdata.
// Put, begin-sprite and sprite-character beats do any cell write in the accept
// cycle and register their result there. An on-screen read waits in S_READ for
// the registered read port of the cell memory; its result appears in the cycle
// after the one in which a put's result would appear.
// Clear sweeps the cell memory one cell a cycle, all COLUMNS*ROWS cells, and
// then returns its result; no beat is taken meanwhile.
// After reset the same sweep runs without a result, so the buffer starts as
// all spaces with attribute 0 and in_tready stays low.
// The output register holds a result until out_tready; a new command is
// taken only when that register is empty or being emptied in that cycle,
// so a stalled receiver stalls the input side after one pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module text_cell_frame_buffer
  import tcfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // pos_x[15:0], pos_y[31:16], sprite_width[41:32], sprite_height[51:42],
  // character[59:52], attribute[75:60], zero fill [79:76]
  input  wire logic [79:0] in_tdata,
  // command[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // cell_char[7:0], cell_attribute[23:8]
  output logic [23:0]      out_tdata,
  // status[2:0]
  output logic [2:0]       out_tuser
);

  // input fields
  cmd_t                       cmd;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic        [SIZE_W-1:0]   spr_w;
  logic        [SIZE_W-1:0]   spr_h;
  logic        [CHAR_W-1:0]   chr;
  logic        [ATTR_W-1:0]   attr;

  assign cmd   = cmd_t'(in_tuser);
  assign pos_x = in_tdata[15:0];
  assign pos_y = in_tdata[31:16];
  assign spr_w = in_tdata[41:32];
  assign spr_h = in_tdata[51:42];
  assign chr   = in_tdata[59:52];
  assign attr  = in_tdata[75:60];

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]  sweep_cnt_r, sweep_cnt_nxt;
  logic               sweep_report_r, sweep_report_nxt;
  logic [COORD_W-1:0] cur_col_r, cur_col_nxt;
  logic [COORD_W-1:0] cur_row_r, cur_row_nxt;
  logic [COORD_W-1:0] start_col_r, start_col_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r;
  logic [CELL_W-1:0]  out_data_r;

  logic               accept;
  logic               sweep_last;
  logic               slot_free;
  logic               is_newline;

  logic signed [COORD_W-1:0] loc_col;
  logic signed [COORD_W-1:0] loc_row;
  cell_loc_t                 loc;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [CELL_W-1:0] ram_wdata;
  logic [CELL_W-1:0] ram_rdata;

  logic              load_out;
  status_t           res_status;
  logic [CELL_W-1:0] res_data;

  assign slot_free  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign sweep_last = (sweep_cnt_r == ADDR_W'(CELLS - 1));
  assign is_newline = (chr == NEWLINE_CODE);

  // sprite characters land at the cursor, everything else at pos_x/pos_y
  assign loc_col = (cmd == CMD_SPRITE) ? cur_col_r : pos_x;
  assign loc_row = (cmd == CMD_SPRITE) ? cur_row_r : pos_y;

  tcfb_addr u_addr (
    .col (loc_col),
    .row (loc_row),
    .loc (loc)
  );

  tcfb_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP: begin
        if (sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && cmd == CMD_CLEAR) begin
          state_nxt = S_SWEEP;
        end else if (accept && cmd == CMD_READ && loc.hit) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_tready        = 1'b0;
    ram_we           = 1'b0;
    ram_addr         = loc.addr;
    ram_wdata        = {attr, chr};
    load_out         = 1'b0;
    res_status       = ST_OUTSIDE;
    res_data         = '0;
    sweep_cnt_nxt    = sweep_cnt_r;
    sweep_report_nxt = sweep_report_r;
    cur_col_nxt      = cur_col_r;
    cur_row_nxt      = cur_row_r;
    start_col_nxt    = start_col_r;

    unique case (state_r)
      S_SWEEP: begin
        ram_we        = 1'b1;
        ram_addr      = sweep_cnt_r;
        ram_wdata     = {ATTR_W'(0), SPACE_CODE};
        sweep_cnt_nxt = sweep_cnt_r + ADDR_W'(1);
        if (sweep_last) begin
          sweep_cnt_nxt    = '0;
          sweep_report_nxt = 1'b0;
          // slot is free: clear was only taken with the output register empty or being emptied
          load_out         = sweep_report_r;
          res_status       = ST_CLEARED;
        end
      end
      S_IDLE: begin
        in_tready = slot_free;
        if (accept) begin
          case (cmd)
            CMD_CLEAR: begin
              sweep_report_nxt = 1'b1;
            end
            CMD_PUT: begin
              load_out   = 1'b1;
              ram_we     = loc.hit;
              res_status = loc.hit ? ST_WRITTEN : ST_OUTSIDE;
            end
            CMD_BEGIN: begin
              load_out      = 1'b1;
              res_status    = ST_MOVED;
              start_col_nxt = pos_x - COORD_W'(spr_w[SIZE_W-1:1]);
              cur_col_nxt   = pos_x - COORD_W'(spr_w[SIZE_W-1:1]);
              cur_row_nxt   = pos_y - COORD_W'(spr_h[SIZE_W-1:1]);
            end
            CMD_SPRITE: begin
              load_out = 1'b1;
              if (is_newline) begin
                res_status  = ST_MOVED;
                cur_row_nxt = cur_row_r + COORD_W'(1);
                cur_col_nxt = start_col_r;
              end else begin
                ram_we      = loc.hit;
                res_status  = loc.hit ? ST_WRITTEN : ST_OUTSIDE;
                cur_col_nxt = cur_col_r + COORD_W'(1);
              end
            end
            CMD_READ: begin
              // on-screen reads report next cycle with the memory data
              load_out   = !loc.hit;
              res_status = ST_OUTSIDE;
            end
            default: begin
              load_out   = 1'b1;
              res_status = ST_OUTSIDE;
            end
          endcase
        end
      end
      S_READ: begin
        load_out   = 1'b1;
        res_status = ST_READ;
        res_data   = ram_rdata;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_SWEEP;
      sweep_cnt_r    <= '0;
      sweep_report_r <= 1'b0;
      cur_col_r      <= '0;
      cur_row_r      <= '0;
      start_col_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      sweep_cnt_r    <= sweep_cnt_nxt;
      sweep_report_r <= sweep_report_nxt;
      cur_col_r      <= cur_col_nxt;
      cur_row_r      <= cur_row_nxt;
      start_col_r    <= start_col_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status;
      out_data_r   <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
